>>> hdl/mbar_pkg.sv
// Shared constants, types and helper functions of the bridge converter reader.
`timescale 1ns / 1ps

package mbar_pkg;

   localparam int CHANNELS      = 4;
   localparam int SAMPLE_BITS   = 24;
   localparam int DOUT_BITS     = 4;
   localparam int READING_BITS  = 24;
   localparam int ATTEMPT_BITS  = 16;
   localparam int CHAN_BITS     = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CIDX_BITS     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_BITS      = $clog2(CHANNELS + 1);
   localparam int BIT_IDX_BITS  = $clog2(SAMPLE_BITS + 1);

   localparam logic [CSR_IDX_BITS-1:0] CSR_CHANNELS_USED = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RETRY_LIMIT   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WAIT_INTERVAL = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EXTRA_PULSES  = 2'd3;

   typedef enum logic [1:0] {
      KIND_CLOCK   = 2'd0,
      KIND_READING = 2'd1,
      KIND_TIMEOUT = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                        kind;
      logic                            sck_level;
      logic [CHAN_BITS-1:0]            channel;
      logic signed [READING_BITS-1:0]  reading;
      logic                            last;
      logic [ATTEMPT_BITS-1:0]         attempts;
   } result_type;

   // Sign-extends a sampled word from its top bit and fits it to the reading width.
   function automatic logic signed [READING_BITS-1:0] fit_reading(
      input logic [SAMPLE_BITS-1:0] word
   );
      logic signed [SAMPLE_BITS-1:0] value;
      value = signed'(word);
      return READING_BITS'(value);
   endfunction

endpackage

>>> hdl/multichannel_bridge_adc_reader.sv
// Top level of the parallel reader for bridge converters sharing one serial clock.
`timescale 1ns / 1ps

// Every request word is one tick of the serial clock, and ticks may arrive back to back
// while req_stall is low. Each tick yields at most one clock drive or timeout word.
// The tick after the last falling edge of the serial clock is the exception: it yields one
// reading word per channel in use, and the request side is held after it while the readings
// leave the sample registers one per cycle while the buffer has room. A two-word result
// buffer lets the next tick be taken while a finished word still waits on the result channel.

module multichannel_bridge_adc_reader
   import mbar_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_func,
   input  logic [DOUT_BITS-1:0]            req_dout_bits,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_kind,
   output logic                            rsp_sck_level,
   output logic [CHAN_BITS-1:0]            rsp_channel,
   output logic signed [READING_BITS-1:0]  rsp_reading,
   output logic                            rsp_last,
   output logic [ATTEMPT_BITS-1:0]         rsp_attempts,
   input  logic                            csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]         csr_index,
   input  logic [CSR_DATA_BITS-1:0]        csr_wdata
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WAIT,
      PH_DATA_LO,
      PH_DATA_HI,
      PH_PULSE_LO,
      PH_PULSE_HI,
      PH_EMIT
   } phase_type;

   logic [2:0]              channels_used_ff;
   logic [15:0]             retry_limit_ff;
   logic [15:0]             wait_interval_ff;
   logic [1:0]              extra_pulses_ff;

   phase_type               phase_ff, phase_in;
   logic [BIT_IDX_BITS-1:0] bit_index_ff, bit_index_in;
   logic [SAMPLE_BITS-1:0]  shift_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0]  shift_in [CHANNELS];
   logic [15:0]             retry_count_ff, retry_count_in;
   logic [15:0]             interval_count_ff, interval_count_in;
   logic [1:0]              pulse_count_ff, pulse_count_in;
   logic                    emit_busy_ff, emit_busy_in;
   logic [CIDX_BITS-1:0]    emit_index_ff, emit_index_in;
   logic [CNT_BITS-1:0]     emit_count_ff, emit_count_in;

   logic [CNT_BITS-1:0]     n_used;
   logic [DOUT_BITS-1:0]    chan_mask;
   logic                    ready;
   logic [15:0]             interval;
   logic [15:0]             interval_inc;
   logic [15:0]             retry_inc;
   logic [1:0]              pulse_inc;
   logic [BIT_IDX_BITS-1:0] bit_inc;
   logic                    emit_last;
   logic                    accept;
   logic                    push_valid;
   result_type              push_data;
   logic                    queue_full;
   result_type              rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         channels_used_ff <= 3'd4;
         retry_limit_ff   <= 16'd10;
         wait_interval_ff <= 16'd1000;
         extra_pulses_ff  <= 2'd1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CHANNELS_USED: channels_used_ff <= csr_wdata[2:0];
            CSR_RETRY_LIMIT:   retry_limit_ff   <= csr_wdata;
            CSR_WAIT_INTERVAL: wait_interval_ff <= csr_wdata;
            CSR_EXTRA_PULSES:  extra_pulses_ff  <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (channels_used_ff == 3'd0) begin
         n_used = CNT_BITS'(1);
      end else if (int'(channels_used_ff) > CHANNELS) begin
         n_used = CNT_BITS'(CHANNELS);
      end else begin
         n_used = CNT_BITS'(channels_used_ff);
      end
      for (int c = 0; c < DOUT_BITS; c++) begin
         chan_mask[c] = (c < int'(n_used));
      end
   end

   assign ready        = ((req_dout_bits & chan_mask) == '0);
   assign interval     = (wait_interval_ff == 16'd0) ? 16'd1 : wait_interval_ff;
   assign interval_inc = interval_count_ff + 16'd1;
   assign retry_inc    = retry_count_ff + 16'd1;
   assign pulse_inc    = pulse_count_ff + 2'd1;
   assign bit_inc      = bit_index_ff + BIT_IDX_BITS'(1);
   assign emit_last    = ((CNT_BITS'(emit_index_ff) + CNT_BITS'(1)) == emit_count_ff);
   assign req_stall    = emit_busy_ff || queue_full;
   assign accept       = req_valid && !req_stall;

   always_comb begin
      phase_in          = phase_ff;
      bit_index_in      = bit_index_ff;
      shift_in          = shift_ff;
      retry_count_in    = retry_count_ff;
      interval_count_in = interval_count_ff;
      pulse_count_in    = pulse_count_ff;
      emit_busy_in      = emit_busy_ff;
      emit_index_in     = emit_index_ff;
      emit_count_in     = emit_count_ff;
      push_valid        = 1'b0;
      push_data         = '0;

      if (emit_busy_ff) begin
         if (!queue_full) begin
            push_valid         = 1'b1;
            push_data.kind     = KIND_READING;
            push_data.channel  = CHAN_BITS'(emit_index_ff);
            push_data.reading  = fit_reading(shift_ff[emit_index_ff]);
            push_data.last     = emit_last;
            push_data.attempts = retry_count_ff;
            emit_index_in      = emit_index_ff + CIDX_BITS'(1);
            if (emit_last) begin
               emit_busy_in  = 1'b0;
               emit_index_in = '0;
            end
         end
      end else if (accept) begin
         if (req_func) begin
            for (int c = 0; c < CHANNELS; c++) begin
               shift_in[c] = '0;
            end
            retry_count_in    = '0;
            interval_count_in = '0;
            pulse_count_in    = '0;
            bit_index_in      = '0;
            if (retry_limit_ff == 16'd0) begin
               phase_in       = PH_IDLE;
               push_valid     = 1'b1;
               push_data.kind = KIND_TIMEOUT;
            end else if (ready) begin
               phase_in            = PH_DATA_HI;
               push_valid          = 1'b1;
               push_data.kind      = KIND_CLOCK;
               push_data.sck_level = 1'b1;
            end else begin
               phase_in = PH_WAIT;
            end
         end else begin
            case (phase_ff)
               PH_WAIT: begin
                  interval_count_in = interval_inc;
                  if (interval_inc >= interval) begin
                     retry_count_in = retry_inc;
                     if (retry_inc >= retry_limit_ff) begin
                        phase_in           = PH_IDLE;
                        push_valid         = 1'b1;
                        push_data.kind     = KIND_TIMEOUT;
                        push_data.attempts = retry_inc;
                     end else if (ready) begin
                        bit_index_in        = '0;
                        phase_in            = PH_DATA_HI;
                        push_valid          = 1'b1;
                        push_data.kind      = KIND_CLOCK;
                        push_data.sck_level = 1'b1;
                     end else begin
                        interval_count_in = '0;
                     end
                  end
               end
               PH_DATA_LO: begin
                  phase_in            = PH_DATA_HI;
                  push_valid          = 1'b1;
                  push_data.kind      = KIND_CLOCK;
                  push_data.sck_level = 1'b1;
               end
               PH_DATA_HI: begin
                  for (int c = 0; c < CHANNELS; c++) begin
                     if (chan_mask[c]) begin
                        shift_in[c] = {shift_ff[c][SAMPLE_BITS-2:0], req_dout_bits[c]};
                     end
                  end
                  bit_index_in = bit_inc;
                  if (bit_inc < BIT_IDX_BITS'(SAMPLE_BITS)) begin
                     phase_in = PH_DATA_LO;
                  end else begin
                     pulse_count_in = '0;
                     phase_in = (extra_pulses_ff != 2'd0) ? PH_PULSE_LO : PH_EMIT;
                  end
                  push_valid     = 1'b1;
                  push_data.kind = KIND_CLOCK;
               end
               PH_PULSE_LO: begin
                  phase_in            = PH_PULSE_HI;
                  push_valid          = 1'b1;
                  push_data.kind      = KIND_CLOCK;
                  push_data.sck_level = 1'b1;
               end
               PH_PULSE_HI: begin
                  pulse_count_in = pulse_inc;
                  phase_in       = (pulse_inc < extra_pulses_ff) ? PH_PULSE_LO : PH_EMIT;
                  push_valid     = 1'b1;
                  push_data.kind = KIND_CLOCK;
               end
               PH_EMIT: begin
                  emit_busy_in  = 1'b1;
                  emit_index_in = '0;
                  emit_count_in = n_used;
                  phase_in      = PH_IDLE;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         bit_index_ff      <= '0;
         retry_count_ff    <= '0;
         interval_count_ff <= '0;
         pulse_count_ff    <= '0;
         emit_busy_ff      <= 1'b0;
         emit_index_ff     <= '0;
         emit_count_ff     <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            shift_ff[c] <= '0;
         end
      end else begin
         phase_ff          <= phase_in;
         bit_index_ff      <= bit_index_in;
         retry_count_ff    <= retry_count_in;
         interval_count_ff <= interval_count_in;
         pulse_count_ff    <= pulse_count_in;
         emit_busy_ff      <= emit_busy_in;
         emit_index_ff     <= emit_index_in;
         emit_count_ff     <= emit_count_in;
         shift_ff          <= shift_in;
      end
   end

   mbar_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   assign rsp_kind      = rsp_data.kind;
   assign rsp_sck_level = rsp_data.sck_level;
   assign rsp_channel   = rsp_data.channel;
   assign rsp_reading   = rsp_data.reading;
   assign rsp_last      = rsp_data.last;
   assign rsp_attempts  = rsp_data.attempts;

endmodule

>>> hdl/mbar_rsp_queue.sv
// Two-word result buffer that separates the sequencer from the result channel.
`timescale 1ns / 1ps

module mbar_rsp_queue
   import mbar_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   input  result_type push_data,
   output logic       full,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_data
);

   result_type entry_ff [2];
   result_type entry_in [2];
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic [1:0] count_after;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign rsp_data  = entry_ff[0];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      entry_in[0] = entry_ff[0];
      entry_in[1] = entry_ff[1];
      if (pop) begin
         entry_in[0] = entry_ff[1];
      end
      count_after = count_ff - {1'b0, pop};
      if (push_valid) begin
         entry_in[count_after[0]] = push_data;
      end
      count_in = count_after + {1'b0, push_valid};
   end

   always_ff @(posedge clock) begin
      entry_ff[0] <= entry_in[0];
      entry_ff[1] <= entry_in[1];
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

>>> hdl/mbar_checker.sv
// Port-level checker of the bridge converter reader and its bind to the top level.
`timescale 1ns / 1ps

module mbar_checker
   import mbar_pkg::*;
(
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [1:0]                      rsp_kind,
   input logic                            rsp_sck_level,
   input logic [CHAN_BITS-1:0]            rsp_channel,
   input logic signed [READING_BITS-1:0]  rsp_reading,
   input logic                            rsp_last,
   input logic [ATTEMPT_BITS-1:0]         rsp_attempts
);

   // A stalled result word keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_reading)
         && $stable(rsp_channel) && $stable(rsp_last) && $stable(rsp_attempts)
         && $stable(rsp_sck_level))
      else $error("result word changed while stalled");

   // Only a reading carries a channel index or the last marker.
   a_last_on_reading: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_READING |-> !rsp_last && rsp_channel == '0)
      else $error("channel or last marker on a word that is not a reading");

   // The readings of one set leave without a gap, in rising channel order.
   a_reading_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_kind == KIND_READING && !rsp_last
      |=> rsp_valid && rsp_kind == KIND_READING
         && rsp_channel == $past(rsp_channel) + CHAN_BITS'(1))
      else $error("reading set broken off or out of order");

   // Reset leaves no result word pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

endmodule

bind multichannel_bridge_adc_reader mbar_checker u_mbar_checker (.*);

>>> bench/testbench.sv
// Self-checking testbench for the parallel bridge converter reader.
`timescale 1ns / 1ps

module testbench;
   import mbar_pkg::*;

   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 300;
   localparam int STUCK_LIMIT   = 2000;

   typedef struct packed {
      logic                 func;
      logic [DOUT_BITS-1:0] dout;
   } tick_type;

   typedef enum logic [2:0] {
      P_IDLE, P_WAIT, P_DATA_LO, P_DATA_HI, P_PULSE_LO, P_PULSE_HI, P_EMIT
   } reader_phase_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_func = 1'b0;
   logic [DOUT_BITS-1:0]           req_dout_bits = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [1:0]                     rsp_kind;
   logic                           rsp_sck_level;
   logic [CHAN_BITS-1:0]           rsp_channel;
   logic signed [READING_BITS-1:0] rsp_reading;
   logic                           rsp_last;
   logic [ATTEMPT_BITS-1:0]        rsp_attempts;
   logic                           csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]        csr_index = '0;
   logic [CSR_DATA_BITS-1:0]       csr_wdata = '0;

   tick_type   tick_queue[$];
   result_type expected_words[$];
   int         fail_count = 0;
   int         gap_left = 0;
   int         stall_left = 0;
   int         hold_left = 0;
   int         stuck_cycles = 0;
   bit         calm = 1'b0;
   bit         hold_request = 1'b0;

   logic [2:0]              cfg_chans = 3'd4;
   logic [15:0]             cfg_retry = 16'd10;
   logic [15:0]             cfg_interval = 16'd1000;
   logic [1:0]              cfg_pulses = 2'd1;

   reader_phase_type        rd_phase = P_IDLE;
   logic [4:0]              sample_bit = '0;
   logic [SAMPLE_BITS-1:0]  shift_regs[CHANNELS] = '{default: '0};
   logic [15:0]             retries = '0;
   logic [15:0]             interval_ticks = '0;
   logic [1:0]              pulses_done = '0;

   multichannel_bridge_adc_reader i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_dout_bits (req_dout_bits),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_sck_level (rsp_sck_level),
      .rsp_channel   (rsp_channel),
      .rsp_reading   (rsp_reading),
      .rsp_last      (rsp_last),
      .rsp_attempts  (rsp_attempts),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int used_count();
      if (cfg_chans == 0) return 1;
      if (cfg_chans > CHANNELS) return CHANNELS;
      return int'(cfg_chans);
   endfunction

   function automatic result_type make_word(kind_type k, logic sck, logic [CHAN_BITS-1:0] ch,
                                            logic [READING_BITS-1:0] rd, logic lst,
                                            logic [ATTEMPT_BITS-1:0] att);
      return '{k, sck, ch, rd, lst, att};
   endfunction

   task automatic clock_or_wait(input logic [DOUT_BITS-1:0] dout, input int n);
      bit ready;
      ready = 1'b1;
      for (int c = 0; c < n; c++)
         if (dout[c]) ready = 1'b0;
      if (ready) begin
         sample_bit = '0;
         rd_phase = P_DATA_HI;
         expected_words.push_back(make_word(KIND_CLOCK, 1'b1, '0, '0, 1'b0, '0));
      end else begin
         interval_ticks = '0;
         rd_phase = P_WAIT;
      end
   endtask

   task automatic advance_reader(input logic func, input logic [DOUT_BITS-1:0] dout);
      int n;
      logic [15:0] span;
      n = used_count();
      if (func) begin
         for (int c = 0; c < CHANNELS; c++) shift_regs[c] = '0;
         retries = '0;
         interval_ticks = '0;
         pulses_done = '0;
         sample_bit = '0;
         if (cfg_retry == 0) begin
            rd_phase = P_IDLE;
            expected_words.push_back(make_word(KIND_TIMEOUT, 1'b0, '0, '0, 1'b0, '0));
         end else begin
            clock_or_wait(dout, n);
         end
         return;
      end
      case (rd_phase)
         P_WAIT: begin
            span = (cfg_interval == 0) ? 16'd1 : cfg_interval;
            interval_ticks = interval_ticks + 16'd1;
            if (interval_ticks >= span) begin
               retries = retries + 16'd1;
               if (retries >= cfg_retry) begin
                  rd_phase = P_IDLE;
                  expected_words.push_back(make_word(KIND_TIMEOUT, 1'b0, '0, '0, 1'b0,
                                                     retries));
               end else begin
                  clock_or_wait(dout, n);
               end
            end
         end
         P_DATA_LO: begin
            rd_phase = P_DATA_HI;
            expected_words.push_back(make_word(KIND_CLOCK, 1'b1, '0, '0, 1'b0, '0));
         end
         P_DATA_HI: begin
            for (int c = 0; c < n; c++)
               shift_regs[c] = {shift_regs[c][SAMPLE_BITS-2:0], dout[c]};
            sample_bit = sample_bit + 5'd1;
            if (sample_bit < SAMPLE_BITS) begin
               rd_phase = P_DATA_LO;
            end else begin
               pulses_done = '0;
               rd_phase = (cfg_pulses != 0) ? P_PULSE_LO : P_EMIT;
            end
            expected_words.push_back(make_word(KIND_CLOCK, 1'b0, '0, '0, 1'b0, '0));
         end
         P_PULSE_LO: begin
            rd_phase = P_PULSE_HI;
            expected_words.push_back(make_word(KIND_CLOCK, 1'b1, '0, '0, 1'b0, '0));
         end
         P_PULSE_HI: begin
            pulses_done = pulses_done + 2'd1;
            rd_phase = (pulses_done < cfg_pulses) ? P_PULSE_LO : P_EMIT;
            expected_words.push_back(make_word(KIND_CLOCK, 1'b0, '0, '0, 1'b0, '0));
         end
         P_EMIT: begin
            for (int c = 0; c < n; c++)
               expected_words.push_back(make_word(KIND_READING, 1'b0, CHAN_BITS'(c),
                                                  shift_regs[c], c == n - 1, retries));
            rd_phase = P_IDLE;
         end
         default: rd_phase = P_IDLE;
      endcase
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : driver
      tick_type next_tick;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left--;
         end else if (tick_queue.size() != 0) begin
            next_tick = tick_queue.pop_front();
            req_valid <= 1'b1;
            req_func <= next_tick.func;
            req_dout_bits <= next_tick.dout;
            if (!calm && $urandom_range(0, 2) == 0)
               gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (!calm && $urandom_range(0, 3) == 0)
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                     : $urandom_range(1, 3);
      end
   end

   always @(posedge clock) begin : monitor
      result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) advance_reader(req_func, req_dout_bits);
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("unexpected result word: kind %0d, sck %0b, channel %0d, reading %0h",
                      rsp_kind, rsp_sck_level, rsp_channel, rsp_reading);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("sck_level", want.sck_level, rsp_sck_level);
               check_field("channel", want.channel, rsp_channel);
               check_field("reading", want.reading, rsp_reading);
               check_field("last", want.last, rsp_last);
               check_field("attempts", want.attempts, rsp_attempts);
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles = 0;
         else stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_CHANNELS_USED: cfg_chans = value[2:0];
         CSR_RETRY_LIMIT:   cfg_retry = value;
         CSR_WAIT_INTERVAL: cfg_interval = value;
         default:           cfg_pulses = value[1:0];
      endcase
   endtask

   task automatic set_config(input int chans, input int retry, input int span, input int gain);
      write_reg(CSR_CHANNELS_USED, CSR_DATA_BITS'(chans));
      write_reg(CSR_RETRY_LIMIT, CSR_DATA_BITS'(retry));
      write_reg(CSR_WAIT_INTERVAL, CSR_DATA_BITS'(span));
      write_reg(CSR_EXTRA_PULSES, CSR_DATA_BITS'(gain));
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (tick_queue.size() != 0 || req_valid || expected_words.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // A request and ticks for a whole conversion, or cut ticks. The extreme form
   // shifts in the most negative, most positive, zero and minus-one readings.
   task automatic queue_sequence(input bit extreme, input int cut);
      int n;
      int ticks;
      int b;
      bit ready;
      logic [DOUT_BITS-1:0] used_mask;
      logic [DOUT_BITS-1:0] d;
      n = used_count();
      used_mask = DOUT_BITS'((1 << n) - 1);
      ready = extreme || $urandom_range(0, 3) != 0;
      d = DOUT_BITS'($urandom);
      if (ready) d = d & ~used_mask;
      else d = d | (DOUT_BITS'(1) << $urandom_range(0, n - 1));
      tick_queue.push_back('{1'b1, d});
      ticks = 2 * SAMPLE_BITS + 2 * int'(cfg_pulses) + $urandom_range(0, 2);
      if (!ready) ticks += $urandom_range(2, 12);
      if (cut != 0) ticks = cut;
      for (int i = 1; i <= ticks; i++) begin
         d = DOUT_BITS'($urandom);
         if (extreme && i < 2 * SAMPLE_BITS && i % 2 == 1) begin
            b = (i - 1) / 2;
            d = {1'b1, 1'b0, b != 0, b == 0};
         end else if (!extreme && $urandom_range(0, 2) == 0) begin
            d = d & ~used_mask;
         end
         tick_queue.push_back('{1'b0, d});
      end
   endtask

   initial begin
      int sent_items;
      int phase_count;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (!reset);

      sent_items = 0;
      tick_queue.push_back('{1'b0, 4'hF});
      tick_queue.push_back('{1'b0, 4'h0});
      queue_sequence(1'b1, 0);
      sent_items += tick_queue.size();
      wait_drained();

      set_config(0, 0, 0, 0);
      tick_queue.push_back('{1'b1, 4'h0});
      tick_queue.push_back('{1'b0, 4'hF});
      tick_queue.push_back('{1'b1, 4'hF});
      sent_items += tick_queue.size();
      wait_drained();

      set_config(0, 2, 0, 0);
      tick_queue.push_back('{1'b1, 4'hF});
      tick_queue.push_back('{1'b0, 4'hF});
      tick_queue.push_back('{1'b0, 4'hF});
      queue_sequence(1'b1, 0);
      sent_items += tick_queue.size();
      wait_drained();

      set_config(7, 65535, 65535, 3);
      queue_sequence(1'b1, 20);
      queue_sequence(1'b1, 0);
      sent_items += tick_queue.size();
      wait_drained();

      phase_count = 0;
      while (sent_items < 200) begin
         calm = $urandom_range(0, 3) == 0;
         set_config(($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4),
                    ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6),
                    $urandom_range(0, 4), $urandom_range(0, 3));
         repeat ($urandom_range(0, 2)) tick_queue.push_back('{1'b0, DOUT_BITS'($urandom)});
         queue_sequence($urandom_range(0, 5) == 0,
                        ($urandom_range(0, 5) == 0) ? $urandom_range(1, 40) : 0);
         sent_items += tick_queue.size();
         if (phase_count == 0) hold_request = 1'b1;
         phase_count++;
         wait_drained();
      end

      if (fail_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
